// ----- src/midi_file_event_parser_macros.svh -----
// Assertion helpers used by the checker file of the parser.
`ifndef MIDI_FILE_EVENT_PARSER_MACROS_SVH
`define MIDI_FILE_EVENT_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MFEP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MFEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/midi_fep_pkg.sv -----
`timescale 1ns / 1ps

package midi_fep_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_EVENT   = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_STOPPED = 3'd3;
    localparam logic [2:0] KIND_EOF     = 3'd4;

    // Chunk signatures, big-endian ASCII.
    localparam logic [31:0] SIG_MTHD = 32'h4D54_6864;
    localparam logic [31:0] SIG_MTRK = 32'h4D54_726B;
    localparam logic [31:0] SIG_XFIH = 32'h5846_4948;
    localparam logic [31:0] SIG_XFKM = 32'h5846_4B4D;
    localparam logic [31:0] SIG_CONT = 32'h436F_6E74;

    // Status and meta codes.
    localparam logic [7:0] STATUS_SYSEX        = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_ESC    = 8'hF7;
    localparam logic [7:0] STATUS_SONG_POS     = 8'hF2;
    localparam logic [7:0] STATUS_SONG_SELECT  = 8'hF3;
    localparam logic [7:0] STATUS_REALTIME_MIN = 8'hF8;
    localparam logic [7:0] STATUS_META         = 8'hFF;
    localparam logic [7:0] META_END_OF_TRACK   = 8'h2F;
    localparam logic [3:0] TYPE_PROG_CHANGE    = 4'hC;
    localparam logic [3:0] TYPE_CHAN_PRESSURE  = 4'hD;
    localparam logic [3:0] TYPE_SYSTEM         = 4'hF;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] track_index;
        logic [31:0] delta_time;
        logic [7:0]  status;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [31:0] payload_length;
        logic        last_of_event;
        logic [15:0] file_format;
        logic [15:0] track_count;
        logic [15:0] division;
        logic        stream_done;
    } t_result;

endpackage

// ----- src/midi_fep_parser.sv -----
`timescale 1ns / 1ps

module midi_fep_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  midi_fep_pkg::t_in_item i_item,
    output logic                  o_res_valid,
    output midi_fep_pkg::t_result o_res
);

    typedef enum logic [4:0] {
        PH_HSIG, PH_HLEN, PH_HFMT, PH_HNTRK, PH_HDIV, PH_CSIG, PH_TLEN, PH_SLEN,
        PH_SKIP, PH_DELTA, PH_STAT, PH_D2A, PH_D2B, PH_D1, PH_MTYPE, PH_LEN,
        PH_PAY, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bc, n_bc;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_running, n_running;
    logic [7:0]  r_cur, n_cur;
    logic [31:0] r_delta, n_delta;
    logic [31:0] r_rem, n_rem;
    logic [7:0]  r_first, n_first;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_ntrk, n_ntrk;
    logic [15:0] r_trk, n_trk;

    logic [7:0]  b;
    logic [31:0] acc8, acc7;
    logic [2:0]  bc1;
    logic        emit_ev, emit_plain, do_end, stop;
    logic [2:0]  ev_kind;
    logic [7:0]  ev_first, ev_second;
    logic [31:0] ev_len;
    logic        ev_last;
    midi_fep_pkg::t_result res;

    always_comb begin
        b        = i_item.file_byte;
        acc8     = {r_acc[23:0], b};
        acc7     = {r_acc[24:0], b[6:0]};
        bc1      = r_bc + 3'd1;
        n_phase  = r_phase;
        n_bc     = r_bc;
        n_acc    = r_acc;
        n_running = r_running;
        n_cur    = r_cur;
        n_delta  = r_delta;
        n_rem    = r_rem;
        n_first  = r_first;
        n_fmt    = r_fmt;
        n_ntrk   = r_ntrk;
        n_trk    = r_trk;
        emit_ev  = 1'b0;
        emit_plain = 1'b0;
        do_end   = 1'b0;
        stop     = 1'b0;
        ev_kind  = midi_fep_pkg::KIND_EVENT;
        ev_first = 8'd0;
        ev_second = 8'd0;
        ev_len   = 32'd0;
        ev_last  = 1'b1;
        res      = '0;

        unique case (r_phase)
            PH_HSIG, PH_HLEN, PH_CSIG, PH_TLEN, PH_SLEN: begin
                // Four-byte big-endian fields.
                n_acc = acc8;
                n_bc  = bc1;
                if (bc1 == 3'd4) begin
                    n_bc = 3'd0;
                    if (r_phase == PH_HSIG) begin
                        if (acc8 == midi_fep_pkg::SIG_MTHD) begin
                            n_phase = PH_HLEN;
                        end else begin
                            stop = 1'b1;
                        end
                    end else if (r_phase == PH_HLEN) begin
                        n_phase = PH_HFMT;
                    end else if (r_phase == PH_CSIG) begin
                        if (acc8 == midi_fep_pkg::SIG_MTRK) begin
                            n_phase = PH_TLEN;
                        end else if (acc8 == midi_fep_pkg::SIG_XFIH ||
                                     acc8 == midi_fep_pkg::SIG_XFKM ||
                                     acc8 == midi_fep_pkg::SIG_CONT) begin
                            n_phase = PH_SLEN;
                        end else begin
                            stop = 1'b1;
                        end
                    end else if (r_phase == PH_TLEN) begin
                        n_running = 8'd0;
                        n_acc     = 32'd0;
                        n_phase   = PH_DELTA;
                    end else begin
                        n_rem   = acc8;
                        n_phase = (acc8 != 32'd0) ? PH_SKIP : PH_CSIG;
                    end
                end
            end
            PH_HFMT, PH_HNTRK, PH_HDIV: begin
                n_acc = acc8;
                n_bc  = bc1;
                if (bc1 == 3'd2) begin
                    n_bc = 3'd0;
                    if (r_phase == PH_HFMT) begin
                        n_fmt   = acc8[15:0];
                        n_phase = PH_HNTRK;
                    end else if (r_phase == PH_HNTRK) begin
                        n_ntrk  = acc8[15:0];
                        n_phase = PH_HDIV;
                    end else begin
                        emit_plain      = 1'b1;
                        res.kind        = midi_fep_pkg::KIND_HEADER;
                        res.file_format = r_fmt;
                        res.track_count = r_ntrk;
                        res.division    = acc8[15:0];
                        n_acc           = 32'd0;
                        n_phase         = PH_CSIG;
                    end
                end
            end
            PH_SKIP: begin
                n_rem = r_rem - 32'd1;
                if (n_rem == 32'd0) begin
                    n_phase = PH_CSIG;
                end
            end
            PH_DELTA: begin
                n_acc = acc7;
                if (!b[7]) begin
                    n_delta = acc7;
                    n_phase = PH_STAT;
                end
            end
            PH_STAT: begin
                if (b[7]) begin
                    n_cur   = b;
                    n_first = 8'd0;
                    if (b < midi_fep_pkg::STATUS_SYSEX) begin
                        n_running = b;
                    end else if (b < midi_fep_pkg::STATUS_REALTIME_MIN) begin
                        n_running = 8'd0;
                    end
                    priority if (b[7:4] != midi_fep_pkg::TYPE_SYSTEM) begin
                        n_phase = (b[7:4] == midi_fep_pkg::TYPE_PROG_CHANGE ||
                                   b[7:4] == midi_fep_pkg::TYPE_CHAN_PRESSURE) ?
                                  PH_D1 : PH_D2A;
                    end else if (b == midi_fep_pkg::STATUS_SYSEX ||
                                 b == midi_fep_pkg::STATUS_SYSEX_ESC) begin
                        n_acc   = 32'd0;
                        n_phase = PH_LEN;
                    end else if (b == midi_fep_pkg::STATUS_META) begin
                        n_phase = PH_MTYPE;
                    end else if (b == midi_fep_pkg::STATUS_SONG_POS) begin
                        n_phase = PH_D2A;
                    end else if (b == midi_fep_pkg::STATUS_SONG_SELECT) begin
                        n_phase = PH_D1;
                    end else begin
                        emit_ev = 1'b1;
                        do_end  = 1'b1;
                    end
                end else begin
                    n_cur = r_running;
                    if (r_running == 8'd0) begin
                        // Orphan data byte: empty event, then the byte is a delta.
                        n_first = 8'd0;
                        emit_ev = 1'b1;
                        n_acc   = {24'd0, b};
                        n_delta = {24'd0, b};
                        n_phase = PH_STAT;
                    end else if (r_running[7:4] == midi_fep_pkg::TYPE_PROG_CHANGE ||
                                 r_running[7:4] == midi_fep_pkg::TYPE_CHAN_PRESSURE) begin
                        n_first  = b;
                        emit_ev  = 1'b1;
                        ev_first = b;
                        do_end   = 1'b1;
                    end else begin
                        n_first = b;
                        n_phase = PH_D2B;
                    end
                end
            end
            PH_D2A: begin
                n_first = b;
                n_phase = PH_D2B;
            end
            PH_D2B: begin
                emit_ev   = 1'b1;
                ev_first  = r_first;
                ev_second = b;
                do_end    = 1'b1;
            end
            PH_D1: begin
                ev_first = (r_cur == midi_fep_pkg::STATUS_SONG_SELECT) ? {1'b0, b[6:0]} : b;
                n_first  = ev_first;
                emit_ev  = 1'b1;
                do_end   = 1'b1;
            end
            PH_MTYPE: begin
                n_first = b;
                n_acc   = 32'd0;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_acc = acc7;
                if (!b[7]) begin
                    emit_ev  = 1'b1;
                    ev_first = r_first;
                    if (acc7 == 32'd0) begin
                        do_end = 1'b1;
                    end else begin
                        n_rem   = acc7;
                        ev_len  = acc7;
                        ev_last = 1'b0;
                        n_phase = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                n_rem    = r_rem - 32'd1;
                emit_ev  = 1'b1;
                ev_kind  = midi_fep_pkg::KIND_PAYLOAD;
                ev_first = b;
                ev_len   = r_acc;
                ev_last  = (n_rem == 32'd0);
                do_end   = (n_rem == 32'd0);
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (do_end) begin
            n_acc = 32'd0;
            if (n_cur == midi_fep_pkg::STATUS_META &&
                n_first == midi_fep_pkg::META_END_OF_TRACK) begin
                n_trk   = r_trk + 16'd1;
                n_bc    = 3'd0;
                n_phase = PH_CSIG;
            end else begin
                n_phase = PH_DELTA;
            end
        end

        if (stop) begin
            n_phase         = PH_DONE;
            res.kind        = midi_fep_pkg::KIND_STOPPED;
            res.stream_done = 1'b1;
        end

        if (emit_ev) begin
            res.kind           = ev_kind;
            res.delta_time     = r_delta;
            res.status         = n_cur;
            res.first_data     = ev_first;
            res.second_data    = ev_second;
            res.payload_length = ev_len;
            res.last_of_event  = ev_last;
        end

        res.track_index = r_trk;

        if (i_item.end_of_file && r_phase != PH_DONE) begin
            if (!(emit_ev || emit_plain || stop)) begin
                res      = '0;
                res.kind = midi_fep_pkg::KIND_EOF;
                res.track_index = r_trk;
            end
            res.stream_done = 1'b1;
            n_phase         = PH_DONE;
        end

        o_res       = res;
        o_res_valid = (r_phase != PH_DONE) &&
                      (emit_ev || emit_plain || stop || i_item.end_of_file);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HSIG;
            r_bc      <= 3'd0;
            r_acc     <= 32'd0;
            r_running <= 8'd0;
            r_cur     <= 8'd0;
            r_delta   <= 32'd0;
            r_rem     <= 32'd0;
            r_first   <= 8'd0;
            r_fmt     <= 16'd0;
            r_ntrk    <= 16'd0;
            r_trk     <= 16'd0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_bc      <= n_bc;
            r_acc     <= n_acc;
            r_running <= n_running;
            r_cur     <= n_cur;
            r_delta   <= n_delta;
            r_rem     <= n_rem;
            r_first   <= n_first;
            r_fmt     <= n_fmt;
            r_ntrk    <= n_ntrk;
            r_trk     <= n_trk;
        end
    end

endmodule

// ----- src/midi_fep_out_stage.sv -----
`timescale 1ns / 1ps

module midi_fep_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  midi_fep_pkg::t_result i_res,
    input  logic                  i_ready,
    output logic                  o_free,
    output logic                  o_valid,
    output midi_fep_pkg::t_result o_res
);

    logic                  r_valid;
    midi_fep_pkg::t_result r_res;

    // The stage can take a new result when empty or when its content leaves now.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- src/midi_file_event_parser.sv -----
`timescale 1ns / 1ps
// Standard MIDI File event parser.
// Input channel: one file byte per transfer on i_valid / o_ready, with
// i_end_of_file marking the final byte. Output channel: one result per transfer
// on o_valid / i_ready, fields as separate ports (header, event, payload byte,
// parse stopped or end of file, selected by o_kind).
// A byte is captured in an input register; once the output register is free, the
// parser state machine consumes it and, when it yields a result, loads the output
// register, whose content drives o_valid. While the receiver does not stall, one
// byte can be taken in every cycle, so the sustained rate is one byte per clock.
// The single combinational step from input register to result register sets
// that rate.
// When the receiver stalls, the result waits in the output register while the
// next byte still moves into the input register; bytes that give no result keep
// flowing only as the output register frees up, and o_ready drops once both
// registers are occupied.
// Synchronous active-low reset empties both registers and returns the parser to
// looking for the header signature. After a stop or end-of-file result the
// parser ignores all further bytes until the next reset.
module midi_file_event_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_track_index,
    output logic [31:0] o_delta_time,
    output logic [7:0]  o_status,
    output logic [7:0]  o_first_data,
    output logic [7:0]  o_second_data,
    output logic [31:0] o_payload_length,
    output logic        o_last_of_event,
    output logic [15:0] o_file_format,
    output logic [15:0] o_track_count,
    output logic [15:0] o_division,
    output logic        o_stream_done
);

    logic                   r_in_valid;
    midi_fep_pkg::t_in_item r_in;
    logic                   out_free;
    logic                   take;
    logic                   res_valid;
    midi_fep_pkg::t_result  res;
    midi_fep_pkg::t_result  out_res;

    // The held byte is consumed whenever the output register can take a result.
    assign take    = r_in_valid && out_free;
    assign o_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in.file_byte   <= i_file_byte;
            r_in.end_of_file <= i_end_of_file;
        end
    end

    midi_fep_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (r_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    midi_fep_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res_valid),
        .i_res   (res),
        .i_ready (i_ready),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_track_index    = out_res.track_index;
    assign o_delta_time     = out_res.delta_time;
    assign o_status         = out_res.status;
    assign o_first_data     = out_res.first_data;
    assign o_second_data    = out_res.second_data;
    assign o_payload_length = out_res.payload_length;
    assign o_last_of_event  = out_res.last_of_event;
    assign o_file_format    = out_res.file_format;
    assign o_track_count    = out_res.track_count;
    assign o_division       = out_res.division;
    assign o_stream_done    = out_res.stream_done;

endmodule

// ----- src/midi_fep_checker.sv -----
`timescale 1ns / 1ps
`include "midi_file_event_parser_macros.svh"

module midi_fep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_first_data,
    input logic [31:0] o_payload_length,
    input logic        o_stream_done
);

    // A stalled result stays in place.
    `MFEP_ASSERT_NEXT(a_hold_on_stall, o_valid && !i_ready, o_valid && $stable(o_kind) && $stable(o_first_data), "result changed while stalled")

    // Nothing follows the final result.
    `MFEP_ASSERT_NEXT(a_quiet_after_done, o_valid && i_ready && o_stream_done, !o_valid, "result after parse end")

    // Stop and end-of-file results always end the parse.
    `MFEP_ASSERT_NOW(a_stop_is_done, o_valid && (o_kind == midi_fep_pkg::KIND_STOPPED || o_kind == midi_fep_pkg::KIND_EOF), o_stream_done, "stop result without stream end")

    // A payload byte belongs to an event with a nonzero declared length.
    `MFEP_ASSERT_NOW(a_payload_len, o_valid && o_kind == midi_fep_pkg::KIND_PAYLOAD, o_payload_length != 32'd0, "payload byte with zero length")

endmodule

bind midi_file_event_parser midi_fep_checker u_midi_fep_checker (.*);

// ----- bench/tb_midi_file_event_parser.sv -----
`timescale 1ns / 1ps

module tb_midi_file_event_parser;

    localparam int ITEM_TARGET = 1500;
    localparam int HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Codes used only by the stimulus.
    localparam logic [31:0] SIG_UNKNOWN = 32'h4A55_4E4B;
    localparam logic [3:0] TYPE_NOTE_ON = 4'h9;
    localparam logic [7:0] STATUS_TUNE_REQUEST = 8'hF6;
    localparam logic [7:0] STATUS_TIMING_CLOCK = 8'hF8;

    typedef enum logic [4:0] {
        SMF_HDR_SIG, SMF_HDR_LEN, SMF_HDR_FMT, SMF_HDR_NTRK, SMF_HDR_DIV,
        SMF_CHUNK_SIG, SMF_TRACK_LEN, SMF_SKIP_LEN, SMF_SKIP, SMF_DELTA,
        SMF_STATUS, SMF_DATA2_A, SMF_DATA2_B, SMF_DATA1, SMF_META_TYPE,
        SMF_VAR_LEN, SMF_PAYLOAD, SMF_DONE
    } t_smf_phase;

    typedef enum logic [1:0] {
        PACE_FULL, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH
    } t_pace;

    typedef enum logic [1:0] {
        END_QUIET_EOF, END_EOF_ON_EVENT, END_UNKNOWN_CHUNK
    } t_ending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_file_byte = '0;
    logic        i_end_of_file = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [15:0] o_track_index;
    logic [31:0] o_delta_time;
    logic [7:0]  o_status;
    logic [7:0]  o_first_data;
    logic [7:0]  o_second_data;
    logic [31:0] o_payload_length;
    logic        o_last_of_event;
    logic [15:0] o_file_format;
    logic [15:0] o_track_count;
    logic [15:0] o_division;
    logic        o_stream_done;

    midi_file_event_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_file_byte      (i_file_byte),
        .i_end_of_file    (i_end_of_file),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_track_index    (o_track_index),
        .o_delta_time     (o_delta_time),
        .o_status         (o_status),
        .o_first_data     (o_first_data),
        .o_second_data    (o_second_data),
        .o_payload_length (o_payload_length),
        .o_last_of_event  (o_last_of_event),
        .o_file_format    (o_file_format),
        .o_track_count    (o_track_count),
        .o_division       (o_division),
        .o_stream_done    (o_stream_done)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and scoreboard storage.
    midi_fep_pkg::t_in_item file_bytes_pending[$];
    midi_fep_pkg::t_result  expected_results[$];
    t_pace    pace = PACE_FULL;
    t_ending  ending;
    bit       hold_armed = 1'b0;
    bit       hold_used = 1'b0;
    int       hold_left = 0;
    bit       byte_accepted = 1'b0;
    int       bytes_in = 0;
    int       results_checked = 0;
    int       fail_count = 0;
    int       idle_cycles = 0;
    int       kind_seen[0:7];
    int       tracks_built = 0;

    // Generator view of running status, so that most events are well formed.
    logic [7:0] gen_run = '0;
    bit         gen_delta_taken = 1'b0;

    // Parser state as the predictor tracks it.
    t_smf_phase  smf_phase = SMF_HDR_SIG;
    logic [2:0]  smf_count = '0;
    logic [31:0] smf_acc = '0;
    logic [7:0]  smf_run = '0;
    logic [7:0]  smf_cur = '0;
    logic [31:0] smf_delta = '0;
    logic [31:0] smf_left = '0;
    logic [7:0]  smf_first = '0;
    logic [15:0] smf_format = '0;
    logic [15:0] smf_ntracks = '0;
    logic [15:0] smf_track = '0;

    // Shifts one byte into the big-endian accumulator; true once `need` bytes are in.
    function automatic bit smf_gather(input logic [7:0] b, input logic [2:0] need);
        smf_acc = {smf_acc[23:0], b};
        smf_count = smf_count + 3'd1;
        if (smf_count >= need) begin
            smf_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic midi_fep_pkg::t_result smf_plain(input logic [2:0] kind);
        midi_fep_pkg::t_result r;
        r = '0;
        r.kind = kind;
        r.track_index = smf_track;
        return r;
    endfunction

    function automatic midi_fep_pkg::t_result smf_event(input logic [2:0] kind,
                                                        input logic [7:0] first,
                                                        input logic [7:0] second,
                                                        input logic [31:0] len,
                                                        input logic last);
        midi_fep_pkg::t_result r;
        r = smf_plain(kind);
        r.delta_time = smf_delta;
        r.status = smf_cur;
        r.first_data = first;
        r.second_data = second;
        r.payload_length = len;
        r.last_of_event = last;
        return r;
    endfunction

    // End-of-Track closes the chunk; anything else goes back to the next delta.
    function automatic void smf_close_event();
        smf_acc = '0;
        if (smf_cur == midi_fep_pkg::STATUS_META
            && smf_first == midi_fep_pkg::META_END_OF_TRACK) begin
            smf_track = smf_track + 16'd1;
            smf_count = '0;
            smf_phase = SMF_CHUNK_SIG;
        end else begin
            smf_phase = SMF_DELTA;
        end
    endfunction

    // Advances the predicted parser by one file byte. Returns 1 with the
    // expected result when the byte yields one.
    function automatic bit smf_predict_byte(input logic [7:0] b, input logic eof,
                                            output midi_fep_pkg::t_result res);
        bit got;
        bit redo;
        logic [7:0] v;
        got = 1'b0;
        res = '0;
        if (smf_phase == SMF_DONE)
            return 1'b0;
        do begin
            redo = 1'b0;
            case (smf_phase)
                SMF_HDR_SIG: if (smf_gather(b, 3'd4)) begin
                    if (smf_acc == midi_fep_pkg::SIG_MTHD) begin
                        smf_phase = SMF_HDR_LEN;
                    end else begin
                        smf_phase = SMF_DONE;
                        res = smf_plain(midi_fep_pkg::KIND_STOPPED);
                        res.stream_done = 1'b1;
                        got = 1'b1;
                    end
                end
                SMF_HDR_LEN: if (smf_gather(b, 3'd4)) smf_phase = SMF_HDR_FMT;
                SMF_HDR_FMT: if (smf_gather(b, 3'd2)) begin
                    smf_format = smf_acc[15:0];
                    smf_phase = SMF_HDR_NTRK;
                end
                SMF_HDR_NTRK: if (smf_gather(b, 3'd2)) begin
                    smf_ntracks = smf_acc[15:0];
                    smf_phase = SMF_HDR_DIV;
                end
                SMF_HDR_DIV: if (smf_gather(b, 3'd2)) begin
                    res = smf_plain(midi_fep_pkg::KIND_HEADER);
                    res.file_format = smf_format;
                    res.track_count = smf_ntracks;
                    res.division = smf_acc[15:0];
                    got = 1'b1;
                    smf_acc = '0;
                    smf_phase = SMF_CHUNK_SIG;
                end
                SMF_CHUNK_SIG: if (smf_gather(b, 3'd4)) begin
                    if (smf_acc == midi_fep_pkg::SIG_MTRK) begin
                        smf_phase = SMF_TRACK_LEN;
                    end else if (smf_acc == midi_fep_pkg::SIG_XFIH
                                 || smf_acc == midi_fep_pkg::SIG_XFKM
                                 || smf_acc == midi_fep_pkg::SIG_CONT) begin
                        smf_phase = SMF_SKIP_LEN;
                    end else begin
                        smf_phase = SMF_DONE;
                        res = smf_plain(midi_fep_pkg::KIND_STOPPED);
                        res.stream_done = 1'b1;
                        got = 1'b1;
                    end
                end
                SMF_TRACK_LEN: if (smf_gather(b, 3'd4)) begin
                    smf_run = '0;
                    smf_acc = '0;
                    smf_phase = SMF_DELTA;
                end
                SMF_SKIP_LEN: if (smf_gather(b, 3'd4)) begin
                    smf_left = smf_acc;
                    smf_phase = (smf_left != 0) ? SMF_SKIP : SMF_CHUNK_SIG;
                end
                SMF_SKIP: begin
                    smf_left = smf_left - 32'd1;
                    if (smf_left == 0) smf_phase = SMF_CHUNK_SIG;
                end
                SMF_DELTA: begin
                    smf_acc = {smf_acc[24:0], b[6:0]};
                    if (!b[7]) begin
                        smf_delta = smf_acc;
                        smf_phase = SMF_STATUS;
                    end
                end
                SMF_STATUS: if (b[7]) begin
                    smf_cur = b;
                    if (b < midi_fep_pkg::STATUS_SYSEX) smf_run = b;
                    else if (b < midi_fep_pkg::STATUS_REALTIME_MIN) smf_run = '0;
                    smf_first = '0;
                    if (b[7:4] != midi_fep_pkg::TYPE_SYSTEM) begin
                        smf_phase = (b[7:4] == midi_fep_pkg::TYPE_PROG_CHANGE
                                     || b[7:4] == midi_fep_pkg::TYPE_CHAN_PRESSURE)
                                    ? SMF_DATA1 : SMF_DATA2_A;
                    end else begin
                        case (b)
                            midi_fep_pkg::STATUS_SYSEX,
                            midi_fep_pkg::STATUS_SYSEX_ESC: begin
                                smf_acc = '0;
                                smf_phase = SMF_VAR_LEN;
                            end
                            midi_fep_pkg::STATUS_META: smf_phase = SMF_META_TYPE;
                            midi_fep_pkg::STATUS_SONG_POS: smf_phase = SMF_DATA2_A;
                            midi_fep_pkg::STATUS_SONG_SELECT: smf_phase = SMF_DATA1;
                            default: begin
                                // No data bytes: the status byte completes the event.
                                res = smf_event(midi_fep_pkg::KIND_EVENT, '0, '0, '0, 1'b1);
                                got = 1'b1;
                                smf_close_event();
                            end
                        endcase
                    end
                end else begin
                    // Data byte in status position: running status, or an empty
                    // event after which the byte is reread as a one-byte delta.
                    smf_cur = smf_run;
                    smf_first = '0;
                    if (smf_run == 0) begin
                        res = smf_event(midi_fep_pkg::KIND_EVENT, '0, '0, '0, 1'b1);
                        got = 1'b1;
                        smf_close_event();
                    end else begin
                        smf_phase = (smf_run[7:4] == midi_fep_pkg::TYPE_PROG_CHANGE
                                     || smf_run[7:4] == midi_fep_pkg::TYPE_CHAN_PRESSURE)
                                    ? SMF_DATA1 : SMF_DATA2_A;
                    end
                    redo = 1'b1;
                end
                SMF_DATA2_A: begin
                    smf_first = b;
                    smf_phase = SMF_DATA2_B;
                end
                SMF_DATA2_B: begin
                    res = smf_event(midi_fep_pkg::KIND_EVENT, smf_first, b, '0, 1'b1);
                    got = 1'b1;
                    smf_close_event();
                end
                SMF_DATA1: begin
                    v = (smf_cur == midi_fep_pkg::STATUS_SONG_SELECT) ? {1'b0, b[6:0]} : b;
                    smf_first = v;
                    res = smf_event(midi_fep_pkg::KIND_EVENT, v, '0, '0, 1'b1);
                    got = 1'b1;
                    smf_close_event();
                end
                SMF_META_TYPE: begin
                    smf_first = b;
                    smf_acc = '0;
                    smf_phase = SMF_VAR_LEN;
                end
                SMF_VAR_LEN: begin
                    smf_acc = {smf_acc[24:0], b[6:0]};
                    if (!b[7]) begin
                        got = 1'b1;
                        if (smf_acc == 0) begin
                            res = smf_event(midi_fep_pkg::KIND_EVENT, smf_first, '0, '0,
                                            1'b1);
                            smf_close_event();
                        end else begin
                            smf_left = smf_acc;
                            smf_phase = SMF_PAYLOAD;
                            res = smf_event(midi_fep_pkg::KIND_EVENT, smf_first, '0,
                                            smf_acc, 1'b0);
                        end
                    end
                end
                SMF_PAYLOAD: begin
                    smf_left = smf_left - 32'd1;
                    res = smf_event(midi_fep_pkg::KIND_PAYLOAD, b, '0, smf_acc,
                                    smf_left == 0);
                    got = 1'b1;
                    if (smf_left == 0) smf_close_event();
                end
                default: ;
            endcase
        end while (redo);
        if (eof) begin
            if (!got) begin
                res = smf_plain(midi_fep_pkg::KIND_EOF);
                got = 1'b1;
            end
            res.stream_done = 1'b1;
            smf_phase = SMF_DONE;
        end
        return got;
    endfunction

    function automatic string describe(input midi_fep_pkg::t_result r);
        return $sformatf({"kind %0d trk %0d delta %h st %h d1 %h d2 %h len %h last %b",
                          " fmt %h ntrk %h div %h done %b"},
                         r.kind, r.track_index, r.delta_time, r.status, r.first_data,
                         r.second_data, r.payload_length, r.last_of_event, r.file_format,
                         r.track_count, r.division, r.stream_done);
    endfunction

    // ---------------------------------------------------------------------
    // File construction.
    // ---------------------------------------------------------------------
    task automatic put(input logic [7:0] b, input logic eof = 1'b0);
        midi_fep_pkg::t_in_item item;
        item.file_byte = b;
        item.end_of_file = eof;
        file_bytes_pending.insert(file_bytes_pending.size(), item);
    endtask

    task automatic put_word(input logic [31:0] w, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) put(w[8*i +: 8]);
    endtask

    // Variable-length quantity, optionally led by redundant continuation bytes.
    // Random lead bytes push high bits in, and past five groups they wrap out.
    task automatic put_vlq(input logic [31:0] value, input int pad, input bit random_pad);
        int groups;
        logic [6:0] part;
        groups = 1;
        while (groups < 5 && (value >> (7 * groups)) != 0) groups++;
        repeat (pad) put(random_pad ? {1'b1, 7'($urandom)} : 8'h80);
        for (int g = groups - 1; g >= 0; g--) begin
            part = 7'(value >> (7 * g));
            put({g != 0, part});
        end
    endtask

    function automatic logic [7:0] any_data();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
    endfunction

    task automatic build_event();
        int pick;
        int len;
        logic [31:0] delta;
        logic [7:0] st;
        pick = $urandom_range(0, 99);
        delta = (pick < 50) ? $urandom_range(0, 127) :
                (pick < 80) ? $urandom_range(0, 16383) :
                (pick < 95) ? $urandom : 32'hFFFF_FFFF;
        if (!gen_delta_taken)
            put_vlq(delta, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0, 1'b1);
        gen_delta_taken = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            gen_run = st;
            put(st);
            put(any_data());
            if (st[7:4] != midi_fep_pkg::TYPE_PROG_CHANGE
                && st[7:4] != midi_fep_pkg::TYPE_CHAN_PRESSURE) put(any_data());
        end else if (pick < 50) begin
            if (gen_run != 0) begin
                put(8'($urandom_range(0, 127)));
                if (gen_run[7:4] != midi_fep_pkg::TYPE_PROG_CHANGE
                    && gen_run[7:4] != midi_fep_pkg::TYPE_CHAN_PRESSURE)
                    put(any_data());
            end else begin
                // Orphan data byte: the parser rereads it as the next delta.
                put(8'($urandom_range(0, 127)));
                gen_delta_taken = 1'b1;
            end
        end else if (pick < 60) begin
            do st = 8'($urandom_range(8'hF1, 8'hFE));
            while (st == midi_fep_pkg::STATUS_SONG_POS
                   || st == midi_fep_pkg::STATUS_SONG_SELECT
                   || st == midi_fep_pkg::STATUS_SYSEX_ESC);
            if (st < midi_fep_pkg::STATUS_REALTIME_MIN) gen_run = '0;
            put(st);
        end else if (pick < 68) begin
            gen_run = '0;
            if ($urandom_range(0, 1) == 0) begin
                put(midi_fep_pkg::STATUS_SONG_POS);
                put(any_data());
                put(any_data());
            end else begin
                put(midi_fep_pkg::STATUS_SONG_SELECT);
                put(8'($urandom));
            end
        end else begin
            if (pick < 84) begin
                gen_run = '0;
                put($urandom_range(0, 1) ? midi_fep_pkg::STATUS_SYSEX
                                         : midi_fep_pkg::STATUS_SYSEX_ESC);
            end else begin
                put(midi_fep_pkg::STATUS_META);
                do st = 8'($urandom);
                while (st == midi_fep_pkg::META_END_OF_TRACK);
                put(st);
            end
            len = $urandom_range(0, 6);
            put_vlq(len, ($urandom_range(0, 3) == 0) ? 1 : 0, 1'b0);
            repeat (len) put(8'($urandom));
        end
    endtask

    task automatic build_track();
        int n;
        put_word(midi_fep_pkg::SIG_MTRK, 4);
        put_word($urandom, 4);
        gen_run = '0;
        gen_delta_taken = 1'b0;
        n = $urandom_range(4, 40);
        repeat (n) build_event();
        if (!gen_delta_taken) put_vlq($urandom_range(0, 200), 0, 1'b0);
        gen_delta_taken = 1'b0;
        put(midi_fep_pkg::STATUS_META);
        put(midi_fep_pkg::META_END_OF_TRACK);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        put_vlq(n, 0, 1'b0);
        repeat (n) put(8'($urandom));
        tracks_built++;
    endtask

    // ---------------------------------------------------------------------
    // Sender: presents the next pending byte once the previous one is taken.
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin : byte_driver
        midi_fep_pkg::t_in_item item;
        bit gap;
        gap = (pace == PACE_SENDER_GAPS && $urandom_range(0, 99) < 66)
              || (pace == PACE_BOTH && $urandom_range(0, 99) < 15);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || byte_accepted) begin
            if (file_bytes_pending.size() != 0 && !gap) begin
                item = file_bytes_pending.pop_front();
                i_valid <= 1'b1;
                i_file_byte <= item.file_byte;
                i_end_of_file <= item.end_of_file;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls per phase, plus the long hold-off below.
    always @(negedge i_clk) begin : result_sink
        bit stall;
        stall = (pace == PACE_RECEIVER_STALLS && $urandom_range(0, 99) < 66)
                || (pace == PACE_BOTH && $urandom_range(0, 99) < 15);
        i_ready <= i_rst_n && hold_left == 0 && !stall;
    end

    // One long hold-off of the receiver while the sender keeps offering bytes,
    // so both internal registers fill and the input side stalls.
    always @(posedge i_clk) begin : hold_off_timer
        if (hold_armed && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: predicts on every input transfer, checks every output transfer.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : transfer_monitor
        midi_fep_pkg::t_result want;
        midi_fep_pkg::t_result got;
        byte_accepted <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                bytes_in <= bytes_in + 1;
                if (smf_predict_byte(i_file_byte, i_end_of_file, want))
                    expected_results.insert(expected_results.size(), want);
            end
            if (o_valid && i_ready) begin
                got.kind = o_kind;
                got.track_index = o_track_index;
                got.delta_time = o_delta_time;
                got.status = o_status;
                got.first_data = o_first_data;
                got.second_data = o_second_data;
                got.payload_length = o_payload_length;
                got.last_of_event = o_last_of_event;
                got.file_format = o_file_format;
                got.track_count = o_track_count;
                got.division = o_division;
                got.stream_done = o_stream_done;
                results_checked <= results_checked + 1;
                kind_seen[got.kind] <= kind_seen[got.kind] + 1;
                if (expected_results.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("%0t: result with nothing expected: %s", $time,
                                 describe(got));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10) begin
                            $display("%0t: mismatch, expected %s", $time, describe(want));
                            $display("%0t:           actual   %s", $time, describe(got));
                        end
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either channel for too long.
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", idle_cycles);
                $display("midi_file_event_parser regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence.
    // ---------------------------------------------------------------------
    initial begin : sequencer
        int total;
        int pick;
        int len;
        logic [15:0] hdr_word;
        for (int k = 0; k < 8; k++) kind_seen[k] = 0;

        // Header with extreme or random words; the length field is ignored.
        put_word(midi_fep_pkg::SIG_MTHD, 4);
        put_word(32'd6, 4);
        repeat (3) begin
            pick = $urandom_range(0, 2);
            hdr_word = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
            put_word(hdr_word, 2);
        end

        // Directed track: every kind of event and the corner cases.
        put_word(midi_fep_pkg::SIG_MTRK, 4);
        put_word(32'hFFFF_FFFF, 4);
        put(8'h00);
        put(8'h45);                          // data with no running status, reread as delta
        put(STATUS_TUNE_REQUEST);            // event on the status byte itself
        put(8'h7F);
        put(STATUS_TIMING_CLOCK);            // real-time, running status untouched
        put_vlq(32'hFFFF_FFFF, 0, 1'b0);     // largest delta
        put({TYPE_NOTE_ON, 4'h0});
        put(8'h00);
        put(8'h7F);
        put(8'h00);
        put(8'h7F);                          // running status note on
        put(8'h00);
        put(8'h00);
        put({midi_fep_pkg::TYPE_PROG_CHANGE, 4'hF});
        put(8'hFF);
        put(8'h00);
        put(midi_fep_pkg::STATUS_SONG_SELECT);
        put(8'hFF);                          // masked to seven bits
        put(8'h00);
        put(midi_fep_pkg::STATUS_SONG_POS);
        put(8'h12);
        put(8'h34);
        put(8'h00);
        put(midi_fep_pkg::STATUS_SYSEX);
        put(8'h00);                          // zero-length sysex
        put(8'h00);
        put(midi_fep_pkg::STATUS_SYSEX_ESC);
        put(8'h02);
        put(8'hAA);
        put(8'h55);
        put(8'h00);
        put(midi_fep_pkg::STATUS_META);
        put(8'h01);
        put(8'h00);                          // zero-length meta
        put(8'h00);
        put(midi_fep_pkg::STATUS_META);
        put(midi_fep_pkg::META_END_OF_TRACK);
        put(8'h00);
        tracks_built++;
        put_word(midi_fep_pkg::SIG_XFIH, 4);
        put_word(32'd0, 4);
        put_word(midi_fep_pkg::SIG_CONT, 4);
        put_word(32'd2, 4);
        put(8'hFF);
        put(8'h00);
        put_word(midi_fep_pkg::SIG_XFKM, 4);
        put_word(32'd1, 4);
        put(8'h5A);

        // Random tracks, with skipped chunks between some of them.
        while (file_bytes_pending.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 2);
                put_word((pick == 0) ? midi_fep_pkg::SIG_XFIH :
                         (pick == 1) ? midi_fep_pkg::SIG_XFKM : midi_fep_pkg::SIG_CONT, 4);
                len = $urandom_range(0, 8);
                put_word(len, 4);
                repeat (len) put(8'($urandom));
            end
            build_track();
        end

        // The parse ends once per run; the way it ends is chosen at random.
        ending = t_ending'($urandom_range(0, 2));
        case (ending)
            END_QUIET_EOF: put(8'($urandom), 1'b1);
            END_EOF_ON_EVENT: begin
                put_word(midi_fep_pkg::SIG_MTRK, 4);
                put_word(32'd0, 4);
                put(8'h00);
                put({TYPE_NOTE_ON, 4'h3});
                put(8'h3C);
                put(8'h40, 1'b1);
                tracks_built++;
            end
            default: put_word(SIG_UNKNOWN, 4);
        endcase
        // Bytes after the end of the parse must give nothing.
        repeat (6) put(8'($urandom), 1'($urandom));
        total = file_bytes_pending.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pace = PACE_FULL;
        wait (bytes_in >= total / 10);
        hold_armed = 1'b1;
        wait (bytes_in >= total / 5);
        pace = PACE_SENDER_GAPS;
        wait (bytes_in >= 2 * total / 5);
        pace = PACE_RECEIVER_STALLS;
        wait (bytes_in >= 3 * total / 5);
        pace = PACE_BOTH;
        wait (bytes_in >= 4 * total / 5);
        pace = PACE_FULL;

        while (file_bytes_pending.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d file bytes over %0d track chunks gave %0d results",
                 bytes_in, tracks_built, results_checked);
        $display("(%0d events, %0d payload bytes), paced with gaps, stalls and a %0d-cycle %s%s",
                 kind_seen[midi_fep_pkg::KIND_EVENT], kind_seen[midi_fep_pkg::KIND_PAYLOAD],
                 HOLD_CYCLES, "hold-off; stream ended by ", ending.name());
        if (fail_count == 0) begin
            $display("midi_file_event_parser regression: pass");
        end else begin
            $display("%0d mismatching or unexpected results", fail_count);
            $display("midi_file_event_parser regression: fail");
        end
        $finish;
    end

endmodule
